// ===== rtl/lcr_pkg.sv =====
package lcr_pkg;

    // Converter and tare sequence configuration
    localparam int DATA_BITS     = 24;
    localparam int TARE_AVERAGES = 10;
    localparam int TARE_DISCARDS = 3;

    // Field widths
    localparam int RAW_W    = 24;
    localparam int DIFF_W   = RAW_W + 1;
    localparam int SCALE_W  = 32;
    localparam int WEIGHT_W = 57;
    localparam int GAIN_W   = 2;
    localparam int SUM_W    = 28;
    localparam int CNT_W    = $clog2(DATA_BITS + 1);
    localparam int TCNT_W   = $clog2(TARE_DISCARDS + TARE_AVERAGES + 1);

    // Configuration port
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PULSES  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR = CFG_IDX_W'(1);
    localparam logic [GAIN_W-1:0]    GAIN_RESET       = GAIN_W'(1);
    localparam logic [SCALE_W-1:0]   SCALE_RESET      = SCALE_W'(65536);

    // Stream widths
    localparam int S_FIELDS_W = 2;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 1 + RAW_W + WEIGHT_W + 1;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_TUSER_W  = 1;

    // Reciprocal for the tare average: exact for magnitudes below 2**SUM_W.
    // Wide enough to hold 2**RECIP_SHIFT when a single sample is averaged.
    localparam int      RECIP_SHIFT = 31;
    localparam int      RECIP_W     = RECIP_SHIFT + 1;
    localparam longint  RECIP_L     = ((64'sd1 <<< RECIP_SHIFT) + TARE_AVERAGES - 1)
                                      / TARE_AVERAGES;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
    localparam int      PROD_W      = SUM_W + RECIP_W;

    // Readout sequencer phases
    typedef enum logic [2:0] {
        PH_WAIT = 3'b001,
        PH_DATA = 3'b010,
        PH_GAIN = 3'b100
    } phase_t;

    // Step result handed to the tare divider
    typedef struct packed {
        logic                    clock_level;
        logic                    sample_valid;
        logic signed [RAW_W-1:0] raw_sample;
        logic                    tare_busy;
        logic                    tare_done;
        logic                    sum_neg;
        logic [SUM_W-1:0]        sum_mag;
    } step_word_t;

    // Divider result handed to the weight stage
    typedef struct packed {
        logic                    clock_level;
        logic                    sample_valid;
        logic signed [RAW_W-1:0] raw_sample;
        logic                    tare_busy;
        logic                    tare_done;
        logic                    quot_neg;
        logic [RAW_W-1:0]        quot_mag;
    } div_word_t;

    // Final result word
    typedef struct packed {
        logic                       clock_level;
        logic                       sample_valid;
        logic signed [RAW_W-1:0]    raw_sample;
        logic signed [WEIGHT_W-1:0] weight;
        logic                       tare_busy;
    } out_word_t;

endpackage

// ===== rtl/lcr_step.sv =====
module lcr_step (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       dout_level,
    input  logic                       tare_request,
    input  logic [lcr_pkg::GAIN_W-1:0] gain_pulses,
    output logic                       out_valid,
    input  logic                       out_ready,
    output lcr_pkg::step_word_t        out_word
);
    import lcr_pkg::*;

    localparam logic signed [32:0] RAW_MAX = 33'sd8388607;
    localparam logic signed [32:0] RAW_MIN = -33'sd8388608;

    // Input register
    logic a_valid_reg;
    logic a_dout_reg;
    logic a_treq_reg;
    logic a_ready;
    logic step_go;

    // Conversion and tare state
    phase_t                  phase_reg, phase_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [DATA_BITS-1:0]    shift_reg, shift_next;
    logic                    clock_reg, clock_next;
    logic [TCNT_W-1:0]       tcnt_reg, tcnt_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic                    active_reg, active_next;
    logic signed [RAW_W-1:0] raw_reg, raw_next;

    // Result register
    logic       b_valid_reg;
    step_word_t b_word_reg, b_word_next;

    logic                    sample_done;
    logic                    tare_done;
    logic signed [SUM_W-1:0] final_sum;
    logic [CNT_W-1:0]        cnt_inc;
    logic [CNT_W-1:0]        target;
    logic [TCNT_W-1:0]       tcnt_inc;
    logic signed [32:0]      ext_value;
    logic signed [RAW_W-1:0] finished;
    logic b_ready;

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;
    assign step_go  = a_valid_reg && b_ready;

    assign cnt_inc  = cnt_reg + 1'b1;
    assign tcnt_inc = tcnt_reg + 1'b1;
    assign target   = (gain_pulses == '0) ? CNT_W'(1) : CNT_W'(gain_pulses);

    // Sign-extend the shifted value and clamp to the raw range
    always_comb begin
        ext_value = 33'(signed'(shift_reg));
        if (ext_value > RAW_MAX) begin
            finished = RAW_MAX[RAW_W-1:0];
        end else if (ext_value < RAW_MIN) begin
            finished = RAW_MIN[RAW_W-1:0];
        end else begin
            finished = ext_value[RAW_W-1:0];
        end
    end

    // Advance the readout sequencer and the tare sequence by one tick
    always_comb begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        shift_next  = shift_reg;
        clock_next  = clock_reg;
        tcnt_next   = tcnt_reg;
        sum_next    = sum_reg;
        active_next = active_reg;
        raw_next    = raw_reg;
        sample_done = 1'b0;
        tare_done   = 1'b0;
        final_sum   = sum_reg;

        case (phase_reg)
            PH_WAIT: begin
                if (!a_dout_reg) begin
                    clock_next = 1'b1;
                    cnt_next   = '0;
                    shift_next = '0;
                    phase_next = PH_DATA;
                end else begin
                    clock_next = 1'b0;
                end
            end
            PH_DATA: begin
                if (clock_reg) begin
                    shift_next = {shift_reg[DATA_BITS-2:0], a_dout_reg};
                    clock_next = 1'b0;
                    cnt_next   = cnt_inc;
                    if (cnt_inc >= CNT_W'(DATA_BITS)) begin
                        cnt_next   = '0;
                        phase_next = PH_GAIN;
                    end
                end else begin
                    clock_next = 1'b1;
                end
            end
            PH_GAIN: begin
                if (clock_reg) begin
                    clock_next = 1'b0;
                    cnt_next   = cnt_inc;
                    if (cnt_inc >= target) begin
                        raw_next    = finished;
                        sample_done = 1'b1;
                        cnt_next    = '0;
                        phase_next  = PH_WAIT;
                    end
                end else begin
                    clock_next = 1'b1;
                end
            end
            default: begin
                phase_next = PH_WAIT;
                clock_next = 1'b0;
                cnt_next   = '0;
            end
        endcase

        // Count a finished sample toward a running tare
        if (sample_done && active_reg) begin
            if (tcnt_reg >= TCNT_W'(TARE_DISCARDS)) begin
                sum_next = sum_reg + SUM_W'(raw_next);
            end
            tcnt_next = tcnt_inc;
            if (tcnt_inc >= TCNT_W'(TARE_DISCARDS + TARE_AVERAGES)) begin
                tare_done   = 1'b1;
                final_sum   = sum_next;
                active_next = 1'b0;
            end
        end

        // Start a new tare when none is running
        if (a_treq_reg && !active_next) begin
            active_next = 1'b1;
            tcnt_next   = '0;
            sum_next    = '0;
        end

        b_word_next.clock_level  = clock_next;
        b_word_next.sample_valid = sample_done;
        b_word_next.raw_sample   = raw_next;
        b_word_next.tare_busy    = active_next;
        b_word_next.tare_done    = tare_done;
        b_word_next.sum_neg      = final_sum[SUM_W-1];
        b_word_next.sum_mag      = final_sum[SUM_W-1] ? SUM_W'(-final_sum)
                                                      : SUM_W'(final_sum);
    end

    // Capture the input word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_ready) begin
            a_valid_reg <= in_valid;
        end
        if (a_ready && in_valid) begin
            a_dout_reg <= dout_level;
            a_treq_reg <= tare_request;
        end
    end

    // Update state when a word leaves the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_WAIT;
            cnt_reg    <= '0;
            shift_reg  <= '0;
            clock_reg  <= 1'b0;
            tcnt_reg   <= '0;
            sum_reg    <= '0;
            active_reg <= 1'b0;
            raw_reg    <= '0;
        end else if (step_go) begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            shift_reg  <= shift_next;
            clock_reg  <= clock_next;
            tcnt_reg   <= tcnt_next;
            sum_reg    <= sum_next;
            active_reg <= active_next;
            raw_reg    <= raw_next;
        end
    end

    // Hold the step result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_ready) begin
            b_valid_reg <= a_valid_reg;
        end
        if (step_go) begin
            b_word_reg <= b_word_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_word  = b_word_reg;

endmodule

// ===== rtl/lcr_tare_div.sv =====
module lcr_tare_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  lcr_pkg::step_word_t in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output lcr_pkg::div_word_t  out_word
);
    import lcr_pkg::*;

    logic              c_valid_reg;
    div_word_t         c_word_reg, c_word_next;
    logic [PROD_W-1:0] product;
    logic              load;

    assign in_ready = !c_valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // Divide the tare sum magnitude by the average count via reciprocal
    always_comb begin
        product                  = PROD_W'(in_word.sum_mag) * PROD_W'(RECIP);
        c_word_next.clock_level  = in_word.clock_level;
        c_word_next.sample_valid = in_word.sample_valid;
        c_word_next.raw_sample   = in_word.raw_sample;
        c_word_next.tare_busy    = in_word.tare_busy;
        c_word_next.tare_done    = in_word.tare_done;
        c_word_next.quot_neg     = in_word.sum_neg;
        c_word_next.quot_mag     = product[RECIP_SHIFT +: RAW_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (in_ready) begin
            c_valid_reg <= in_valid;
        end
        if (load) begin
            c_word_reg <= c_word_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_word  = c_word_reg;

endmodule

// ===== rtl/lcr_weight.sv =====
module lcr_weight (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  lcr_pkg::div_word_t          in_word,
    input  logic [lcr_pkg::SCALE_W-1:0] scale_factor,
    output logic                        out_valid,
    input  logic                        out_ready,
    output lcr_pkg::out_word_t          out_word
);
    import lcr_pkg::*;

    // Tare offset and the difference stage
    logic signed [RAW_W-1:0]  offset_reg, offset_next;
    logic                     d_valid_reg;
    logic                     d_clock_reg;
    logic                     d_sv_reg;
    logic signed [RAW_W-1:0]  d_raw_reg;
    logic                     d_busy_reg;
    logic signed [DIFF_W-1:0] d_diff_reg, d_diff_next;
    logic                     d_ready;
    logic                     d_load;

    // Output stage
    logic       e_valid_reg;
    out_word_t  e_word_reg, e_word_next;
    logic       e_ready;
    logic       e_load;

    assign e_ready  = !e_valid_reg || out_ready;
    assign d_ready  = !d_valid_reg || e_ready;
    assign in_ready = d_ready;
    assign d_load   = in_valid && d_ready;
    assign e_load   = d_valid_reg && e_ready;

    // Apply a finished tare and take the offset-corrected count
    always_comb begin
        offset_next = offset_reg;
        if (in_word.tare_done) begin
            offset_next = in_word.quot_neg ? RAW_W'(-in_word.quot_mag)
                                           : RAW_W'(in_word.quot_mag);
        end
        d_diff_next = DIFF_W'(in_word.raw_sample) - DIFF_W'(offset_next);
    end

    // Scale to weight
    always_comb begin
        e_word_next.clock_level  = d_clock_reg;
        e_word_next.sample_valid = d_sv_reg;
        e_word_next.raw_sample   = d_raw_reg;
        e_word_next.weight       = WEIGHT_W'(d_diff_reg) * WEIGHT_W'(signed'(scale_factor));
        e_word_next.tare_busy    = d_busy_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg  <= '0;
            d_valid_reg <= 1'b0;
        end else begin
            if (d_ready) begin
                d_valid_reg <= in_valid;
            end
            if (d_load) begin
                offset_reg <= offset_next;
            end
        end
        if (d_load) begin
            d_clock_reg <= in_word.clock_level;
            d_sv_reg    <= in_word.sample_valid;
            d_raw_reg   <= in_word.raw_sample;
            d_busy_reg  <= in_word.tare_busy;
            d_diff_reg  <= d_diff_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else if (e_ready) begin
            e_valid_reg <= d_valid_reg;
        end
        if (e_load) begin
            e_word_reg <= e_word_next;
        end
    end

    assign out_valid = e_valid_reg;
    assign out_word  = e_word_reg;

endmodule

// ===== rtl/load_cell_adc_serial_reader_core.sv =====
// Path: input, step result, divider, difference and output registers. Throughput: one
// word per cycle unless m_tready stalls; the single-pass tick update of the readout
// sequencer and tare state sets that figure, with reciprocal divide and scale multiply
// pipelined. Reset: synchronous, active-low aresetn; sequencer waits for data ready, tare
// offset 0, gain_pulses 1 and scale_factor 1.0 (Q16.16). No clearing pass is needed.
module load_cell_adc_serial_reader_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // config port
    input  logic                          cfg_we,
    input  logic [lcr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lcr_pkg::CFG_W-1:0]     cfg_wdata,
    // input ticks
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lcr_pkg::S_TDATA_W-1:0] s_tdata,   // dout_level, tare_request
    // results
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lcr_pkg::M_TDATA_W-1:0] m_tdata,   // clock_level, raw_sample, weight, tare_busy
    output logic [lcr_pkg::M_TUSER_W-1:0] m_tuser    // sample_valid
);
    import lcr_pkg::*;

    logic [GAIN_W-1:0]  gain_reg;
    logic [SCALE_W-1:0] scale_reg;

    logic       step_valid, step_ready;
    step_word_t step_word;
    logic       div_valid, div_ready;
    div_word_t  div_word;
    out_word_t  res_word;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg  <= GAIN_RESET;
            scale_reg <= SCALE_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_GAIN_PULSES:  gain_reg  <= cfg_wdata[GAIN_W-1:0];
                REG_SCALE_FACTOR: scale_reg <= cfg_wdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    lcr_step u_step (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .dout_level   (s_tdata[0]),
        .tare_request (s_tdata[1]),
        .gain_pulses  (gain_reg),
        .out_valid    (step_valid),
        .out_ready    (step_ready),
        .out_word     (step_word)
    );

    lcr_tare_div u_tare_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (step_valid),
        .in_ready  (step_ready),
        .in_word   (step_word),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_word  (div_word)
    );

    lcr_weight u_weight (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (div_valid),
        .in_ready     (div_ready),
        .in_word      (div_word),
        .scale_factor (scale_reg),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_word     (res_word)
    );

    // Pack the result word
    assign m_tdata = M_TDATA_W'({res_word.tare_busy, res_word.weight,
                                 res_word.raw_sample, res_word.clock_level});
    assign m_tuser = res_word.sample_valid;

endmodule
